[hw/rtl/id3df_pkg.sv]
// ----------------------------------------------------------------------------
// id3df_pkg
// Shared types, constants and helpers for the ID3v2 frame deframer.
// ----------------------------------------------------------------------------
package id3df_pkg;

	localparam int KNOWN_FRAME_COUNT = 8;
	localparam int LEN_W = 28;

	typedef logic [LEN_W-1:0] len_t;

	localparam logic [2:0] OUT_BUSY           = 3'd0;
	localparam logic [2:0] OUT_OK             = 3'd1;
	localparam logic [2:0] OUT_PADDING        = 3'd2;
	localparam logic [2:0] OUT_BAD_HEADER     = 3'd3;
	localparam logic [2:0] OUT_NOT_SYNCHSAFE  = 3'd4;
	localparam logic [2:0] OUT_SKIPPED        = 3'd5;
	localparam logic [2:0] OUT_BAD_FRAME_SIZE = 3'd6;

	localparam logic [15:0] BAD_FRAME_FLAGS = 16'd36784;
	localparam logic [15:0] UNSUPP_FLAGS    = 16'h000C;
	localparam logic [31:0] SYNC_MASK       = 32'h8080_8080;

	localparam int TAG_FLAG_UNSYNC   = 7;
	localparam int TAG_FLAG_EXTENDED = 6;
	localparam int TAG_FLAG_FOOTER   = 4;
	localparam int FRAME_FLAG_UNSYNC = 1;

	localparam logic [31:0] KNOWN_IDS [0:7] = '{
		32'h434F_4D4D, 32'h5458_5858, 32'h5256_4132, 32'h5450_4531,
		32'h5441_4C42, 32'h5449_5432, 32'h5459_4552, 32'h5443_4F4E
	};

	typedef struct packed {
		logic [7:0] tag_byte;
		logic       tag_begin;
	} tag_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic [2:0] frame_kind;
		logic       frame_first;
		logic       frame_last;
		logic       tag_over;
		logic [2:0] outcome;
		logic [2:0] tag_version;
	} result_t;

	function automatic len_t synchsafe(input logic [31:0] a);
		return {a[30:24], a[22:16], a[14:8], a[6:0]};
	endfunction

	function automatic logic is_id_char(input logic [7:0] b);
		return ((b >= 8'd48) && (b <= 8'd57)) || ((b >= 8'd65) && (b <= 8'd90));
	endfunction

endpackage

[hw/rtl/id3df_if.sv]
// ----------------------------------------------------------------------------
// id3df channel interfaces
// Valid/ready channels for tag bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface id3df_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] tag_byte;
	logic       tag_begin;

	modport source(output valid, tag_byte, tag_begin, input ready);
	modport sink(input valid, tag_byte, tag_begin, output ready);
endinterface

interface id3df_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic [2:0] frame_kind;
	logic       frame_first;
	logic       frame_last;
	logic       tag_over;
	logic [2:0] outcome;
	logic [2:0] tag_version;

	modport source(output valid, payload_byte, byte_valid, frame_kind, frame_first,
		frame_last, tag_over, outcome, tag_version, input ready);
	modport sink(input valid, payload_byte, byte_valid, frame_kind, frame_first,
		frame_last, tag_over, outcome, tag_version, output ready);
endinterface

[hw/rtl/id3v2_frame_deframer.sv]
// ----------------------------------------------------------------------------
// id3v2_frame_deframer
// ID3v2 tag parser emitting de-unsynchronised payload of known frames.
// ----------------------------------------------------------------------------
// Feed the tag as a byte stream with tag_begin set on the major version
// byte. One byte is taken per clock cycle, but output back-pressure stalls
// input only when both registers are full; a byte passes an input register,
// the header/frame state machine and a result register before its result is
// presented. Every payload byte of a COMM, TXXX, RVA2, TPE1, TALB, TIT2, TYER
// or TCON frame with supported flags gives one result, an empty such frame
// gives one on its last header byte, and the byte that ends the tag gives one
// with tag_over set and the outcome; other bytes give none.
// ----------------------------------------------------------------------------
module id3v2_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	id3df_in_if.sink    tag_in,
	id3df_out_if.source res_out
);

	logic                 valid_s1;
	id3df_pkg::tag_item_t item_s1;
	logic                 advance;
	logic                 have;
	id3df_pkg::result_t   res;

	id3df_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	id3df_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.item   (item_s1),
		.have   (have),
		.res    (res)
	);

	id3df_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (valid_s1 && advance && have),
		.res     (res),
		.res_out (res_out),
		.advance (advance)
	);

endmodule

[hw/rtl/id3df_in_reg.sv]
// ----------------------------------------------------------------------------
// id3df_in_reg
// Input register stage holding one tag byte transaction for the parser.
// ----------------------------------------------------------------------------
module id3df_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	id3df_in_if.sink             tag_in,
	input  logic                 advance,
	output logic                 valid_s1,
	output id3df_pkg::tag_item_t item_s1
);

	assign tag_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tag_in.ready) begin
			valid_s1 <= tag_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_in.valid && tag_in.ready) begin
			item_s1.tag_byte  <= tag_in.tag_byte;
			item_s1.tag_begin <= tag_in.tag_begin;
		end
	end

endmodule

[hw/rtl/id3df_parser.sv]
// ----------------------------------------------------------------------------
// id3df_parser
// Tag and frame header state machine; one byte per transaction.
// ----------------------------------------------------------------------------
module id3df_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  id3df_pkg::tag_item_t item,
	output logic                 have,
	output id3df_pkg::result_t   res
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_HDR     = 4'd1;
	localparam logic [3:0] PH_SKIPTAG = 4'd2;
	localparam logic [3:0] PH_EXT     = 4'd3;
	localparam logic [3:0] PH_SEEK    = 4'd4;
	localparam logic [3:0] PH_FID     = 4'd5;
	localparam logic [3:0] PH_DATA    = 4'd6;
	localparam logic [3:0] PH_DRAIN   = 4'd7;
	localparam logic [3:0] PH_FOOTER  = 4'd8;

	logic [3:0]       phase_q, phase_d;
	logic [3:0]       hdr_cnt_q, hdr_cnt_d;
	logic [7:0]       major_q, major_d;
	logic [7:0]       hflags_q, hflags_d;
	id3df_pkg::len_t  tag_len_q, tag_len_d;
	id3df_pkg::len_t  body_pos_q, body_pos_d;
	id3df_pkg::len_t  next_pos_q, next_pos_d;
	logic [31:0]      fid_q, fid_d;
	logic [31:0]      acc_q, acc_d;
	logic [15:0]      fflags_q, fflags_d;
	logic [2:0]       kind_q, kind_d;
	logic             prev_ff_q, prev_ff_d;
	logic [3:0]       footer_cnt_q, footer_cnt_d;
	logic [2:0]       held_q, held_d;

	logic             fs_req;
	logic [33:0]      fs_pos;
	logic             fin_req;
	logic             over_req;
	logic [2:0]       over_code;
	logic [7:0]       b;
	logic [33:0]      frame_size;
	logic [33:0]      frame_end;
	logic [15:0]      flags_all;
	logic             found;
	logic [2:0]       kidx;
	id3df_pkg::len_t  ext_len;
	logic             first_b;
	logic             last_b;
	logic             unsync;
	logic             keep;

	always_comb begin
		phase_d      = phase_q;
		hdr_cnt_d    = hdr_cnt_q;
		major_d      = major_q;
		hflags_d     = hflags_q;
		tag_len_d    = tag_len_q;
		body_pos_d   = body_pos_q;
		next_pos_d   = next_pos_q;
		fid_d        = fid_q;
		acc_d        = acc_q;
		fflags_d     = fflags_q;
		kind_d       = kind_q;
		prev_ff_d    = prev_ff_q;
		footer_cnt_d = footer_cnt_q;
		held_d       = held_q;
		fs_req       = 1'b0;
		fs_pos       = '0;
		fin_req      = 1'b0;
		over_req     = 1'b0;
		over_code    = id3df_pkg::OUT_BUSY;
		have         = 1'b0;
		res          = '0;
		b            = item.tag_byte;
		frame_size   = '0;
		frame_end    = '0;
		flags_all    = {fflags_q[15:8], b};
		found        = 1'b0;
		kidx         = '0;
		ext_len      = '0;
		first_b      = 1'b0;
		last_b       = 1'b0;
		unsync       = 1'b0;
		keep         = 1'b1;

		for (int i = 0; i < id3df_pkg::KNOWN_FRAME_COUNT; i++) begin
			if (!found && (id3df_pkg::KNOWN_IDS[i] == fid_q)) begin
				found = 1'b1;
				kidx  = 3'(i);
			end
		end

		if (item.tag_begin) begin
			major_d = '0;
			if (b == 8'hFF) begin
				over_req  = 1'b1;
				over_code = id3df_pkg::OUT_BAD_HEADER;
			end else begin
				major_d   = b;
				phase_d   = PH_HDR;
				hdr_cnt_d = '0;
				acc_d     = '0;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_HDR: begin
					hdr_cnt_d = hdr_cnt_q + 4'd1;
					if (hdr_cnt_q == 4'd0) begin
						if (b == 8'hFF) begin
							major_d   = '0;
							over_req  = 1'b1;
							over_code = id3df_pkg::OUT_BAD_HEADER;
						end
					end else if (hdr_cnt_q == 4'd1) begin
						hflags_d = b;
					end else begin
						acc_d = {acc_q[23:0], b};
						if (hdr_cnt_q == 4'd5) begin
							if ((acc_d & id3df_pkg::SYNC_MASK) != '0) begin
								major_d   = '0;
								over_req  = 1'b1;
								over_code = id3df_pkg::OUT_NOT_SYNCHSAFE;
							end else begin
								tag_len_d  = id3df_pkg::synchsafe(acc_d);
								body_pos_d = '0;
								if ((hflags_q[3:0] != 4'd0) || (major_q < 8'd3) ||
										(major_q > 8'd4)) begin
									major_d = '0;
									held_d  = id3df_pkg::OUT_SKIPPED;
									phase_d = PH_SKIPTAG;
								end else begin
									held_d = id3df_pkg::OUT_OK;
									if (hflags_q[id3df_pkg::TAG_FLAG_EXTENDED]) begin
										phase_d   = PH_EXT;
										hdr_cnt_d = '0;
										acc_d     = '0;
									end else begin
										fs_req = 1'b1;
										fs_pos = '0;
									end
								end
								fin_req = (tag_len_d == '0);
							end
						end
					end
				end
				PH_FOOTER: begin
					footer_cnt_d = footer_cnt_q + 4'd1;
					if (footer_cnt_d >= 4'd10) begin
						over_req  = 1'b1;
						over_code = held_q;
					end
				end
				default: begin
					body_pos_d = body_pos_q + id3df_pkg::len_t'(1);
					case (phase_q)
						PH_EXT: begin
							acc_d     = {acc_q[23:0], b};
							hdr_cnt_d = hdr_cnt_q + 4'd1;
							if (hdr_cnt_d >= 4'd4) begin
								if (major_q == 8'd4) begin
									if ((acc_d & id3df_pkg::SYNC_MASK) != '0) begin
										held_d  = id3df_pkg::OUT_NOT_SYNCHSAFE;
										phase_d = PH_DRAIN;
									end else begin
										ext_len = id3df_pkg::synchsafe(acc_d);
										if (ext_len < id3df_pkg::len_t'(4)) begin
											ext_len = id3df_pkg::len_t'(4);
										end
										fs_req = 1'b1;
										fs_pos = {6'd0, ext_len};
									end
								end else begin
									fs_req = 1'b1;
									fs_pos = {2'd0, acc_d} + 34'd4;
								end
							end
						end
						PH_SEEK: begin
							if (body_pos_d == next_pos_q) begin
								fs_req = 1'b1;
								fs_pos = {6'd0, next_pos_q};
							end
						end
						PH_FID: begin
							if (hdr_cnt_q < 4'd9) begin
								hdr_cnt_d = hdr_cnt_q + 4'd1;
							end
							if (hdr_cnt_q < 4'd4) begin
								if (!id3df_pkg::is_id_char(b)) begin
									held_d  = id3df_pkg::OUT_PADDING;
									phase_d = PH_DRAIN;
								end else begin
									fid_d = {fid_q[23:0], b};
								end
							end else if (hdr_cnt_q < 4'd8) begin
								acc_d = {acc_q[23:0], b};
								if (hdr_cnt_q == 4'd7) begin
									frame_size = {2'd0, acc_d};
									if (major_q == 8'd4) begin
										frame_size = {6'd0, id3df_pkg::synchsafe(acc_d)};
									end
									frame_end = {6'd0, body_pos_d} + 34'd2 + frame_size;
									if ((major_q == 8'd4) &&
											((acc_d & id3df_pkg::SYNC_MASK) != '0)) begin
										held_d  = id3df_pkg::OUT_NOT_SYNCHSAFE;
										phase_d = PH_DRAIN;
									end else if (frame_end > {6'd0, tag_len_q}) begin
										held_d  = id3df_pkg::OUT_BAD_FRAME_SIZE;
										phase_d = PH_DRAIN;
									end else begin
										acc_d      = frame_size[31:0];
										next_pos_d = frame_end[id3df_pkg::LEN_W-1:0];
									end
								end
							end else if (hdr_cnt_q == 4'd8) begin
								fflags_d = {b, 8'h00};
							end else begin
								fflags_d = flags_all;
								if (((flags_all & (id3df_pkg::BAD_FRAME_FLAGS |
										id3df_pkg::UNSUPP_FLAGS)) != '0) || !found) begin
									fs_req = 1'b1;
									fs_pos = {6'd0, next_pos_q};
								end else begin
									kind_d = kidx;
									if (acc_q == '0) begin
										have            = 1'b1;
										res.frame_kind  = kidx;
										res.frame_first = 1'b1;
										res.frame_last  = 1'b1;
										fs_req          = 1'b1;
										fs_pos          = {6'd0, next_pos_q};
									end else begin
										phase_d   = PH_DATA;
										prev_ff_d = 1'b0;
									end
								end
							end
						end
						PH_DATA: begin
							first_b = (body_pos_d == (next_pos_q -
								acc_q[id3df_pkg::LEN_W-1:0] + id3df_pkg::len_t'(1)));
							last_b  = (body_pos_d == next_pos_q);
							unsync  = hflags_q[id3df_pkg::TAG_FLAG_UNSYNC] ||
								fflags_q[id3df_pkg::FRAME_FLAG_UNSYNC];
							keep    = !(unsync && !first_b && prev_ff_q && (b == 8'h00));
							have             = 1'b1;
							res.payload_byte = keep ? b : 8'h00;
							res.byte_valid   = keep;
							res.frame_kind   = kind_q;
							res.frame_first  = first_b;
							res.frame_last   = last_b;
							prev_ff_d        = (b == 8'hFF);
							if (last_b) begin
								fs_req = 1'b1;
								fs_pos = {6'd0, next_pos_q};
							end
						end
						default: begin
						end
					endcase
					fin_req = (body_pos_d >= tag_len_q);
				end
			endcase
		end

		// seek to or start the next frame header, or drain when no room is left
		if (fs_req) begin
			if ((fs_pos + 34'd10) >= {6'd0, tag_len_d}) begin
				phase_d = PH_DRAIN;
			end else begin
				next_pos_d = fs_pos[id3df_pkg::LEN_W-1:0];
				if ({6'd0, body_pos_d} == fs_pos) begin
					phase_d   = PH_FID;
					hdr_cnt_d = '0;
					fid_d     = '0;
					acc_d     = '0;
				end else begin
					phase_d = PH_SEEK;
				end
			end
		end

		if (fin_req) begin
			if (((held_d == id3df_pkg::OUT_OK) || (held_d == id3df_pkg::OUT_SKIPPED)) &&
					hflags_d[id3df_pkg::TAG_FLAG_FOOTER]) begin
				phase_d      = PH_FOOTER;
				footer_cnt_d = '0;
			end else begin
				over_req  = 1'b1;
				over_code = held_d;
			end
		end

		if (over_req) begin
			have         = 1'b1;
			res.tag_over = 1'b1;
			res.outcome  = over_code;
			phase_d      = PH_IDLE;
		end

		res.tag_version = major_d[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hdr_cnt_q    <= '0;
			major_q      <= '0;
			hflags_q     <= '0;
			tag_len_q    <= '0;
			body_pos_q   <= '0;
			next_pos_q   <= '0;
			fid_q        <= '0;
			acc_q        <= '0;
			fflags_q     <= '0;
			kind_q       <= '0;
			prev_ff_q    <= 1'b0;
			footer_cnt_q <= '0;
			held_q       <= id3df_pkg::OUT_BUSY;
		end else if (fire) begin
			phase_q      <= phase_d;
			hdr_cnt_q    <= hdr_cnt_d;
			major_q      <= major_d;
			hflags_q     <= hflags_d;
			tag_len_q    <= tag_len_d;
			body_pos_q   <= body_pos_d;
			next_pos_q   <= next_pos_d;
			fid_q        <= fid_d;
			acc_q        <= acc_d;
			fflags_q     <= fflags_d;
			kind_q       <= kind_d;
			prev_ff_q    <= prev_ff_d;
			footer_cnt_q <= footer_cnt_d;
			held_q       <= held_d;
		end
	end

endmodule

[hw/rtl/id3df_out_reg.sv]
// ----------------------------------------------------------------------------
// id3df_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module id3df_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  id3df_pkg::result_t res,
	id3df_out_if.source        res_out,
	output logic               advance
);

	logic               valid_q;
	id3df_pkg::result_t res_q;

	assign advance = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign res_out.valid        = valid_q;
	assign res_out.payload_byte = res_q.payload_byte;
	assign res_out.byte_valid   = res_q.byte_valid;
	assign res_out.frame_kind   = res_q.frame_kind;
	assign res_out.frame_first  = res_q.frame_first;
	assign res_out.frame_last   = res_q.frame_last;
	assign res_out.tag_over     = res_q.tag_over;
	assign res_out.outcome      = res_q.outcome;
	assign res_out.tag_version  = res_q.tag_version;

endmodule
